/* sv/kt_pkg.sv */
// shared types and constants of the keyword tokenizer
package kt_pkg;

   // byte codes with a special meaning
   localparam logic [7:0] KT_END_OF_TEXT = 8'h00;
   localparam logic [7:0] KT_HYPHEN      = 8'h2D;
   localparam logic [7:0] KT_DIGIT_LO    = 8'h30;
   localparam logic [7:0] KT_DIGIT_HI    = 8'h39;
   localparam logic [7:0] KT_UPPER_LO    = 8'h41;
   localparam logic [7:0] KT_UPPER_HI    = 8'h5A;
   localparam logic [7:0] KT_LOWER_LO    = 8'h61;
   localparam logic [7:0] KT_LOWER_HI    = 8'h7A;

   // latin-1 letters that count as word bytes
   localparam logic [7:0] KT_LAT_A_UML_LC = 8'hE4;
   localparam logic [7:0] KT_LAT_O_UML_LC = 8'hF6;
   localparam logic [7:0] KT_LAT_U_UML_LC = 8'hFC;
   localparam logic [7:0] KT_LAT_A_UML_UC = 8'hC4;
   localparam logic [7:0] KT_LAT_O_UML_UC = 8'hD6;
   localparam logic [7:0] KT_LAT_U_UML_UC = 8'hDC;
   localparam logic [7:0] KT_LAT_SHARP_S  = 8'hDF;

   // shortest word that is emitted
   localparam int unsigned KT_MIN_KEEP_BYTES = 3;

   // classification of one text byte
   typedef struct packed {
      logic ascii_word;
      logic word;
      logic end_of_text;
   } char_class_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_FETCH = 3'b010,
      ST_SEND  = 3'b100
   } state_type;

endpackage

/* sv/kt_if.sv */
// handshake channels for text items and keyword byte items
interface kt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;

   modport source (output valid, output text_byte, input ready);
   modport sink   (input valid, input text_byte, output ready);
endinterface

interface kt_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] word_byte;
   logic       word_end;

   modport source (output valid, output word_byte, output word_end, input ready);
   modport sink   (input valid, input word_byte, input word_end, output ready);
endinterface

/* sv/keyword_tokenizer.sv */
// Keyword tokenizer: word bytes are accepted one per cycle while idle and buffered in a word store.
// After a delimiter or end of text, the first keyword byte passes the fetch and send states to the
// output register, then one byte per cycle while the sink is ready, read from the read port of the
// word store. Input is held off while a word is fetched and sent, and longer while the sink stalls.
// Reset clears the byte count, skip mode, sequencer and output valid; the store is not cleared.
module keyword_tokenizer #(
   parameter int unsigned MAX_WORD_BYTES = 48
) (
   input  logic        clock,
   input  logic        reset,
   kt_req_if.sink      req_item,
   kt_rsp_if.source    rsp_item
);
   import kt_pkg::*;

   localparam int unsigned CNT_W  = $clog2(MAX_WORD_BYTES + 1);
   localparam int unsigned ADDR_W = $clog2(MAX_WORD_BYTES);

   // word store, one write and one registered read port
   logic [7:0] word_store [MAX_WORD_BYTES];

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              skip_ff, skip_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [7:0]        rd_data_ff;
   logic [ADDR_W-1:0] rd_addr;
   logic              wr_en;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        word_byte_ff, word_byte_in;
   logic              word_end_ff, word_end_in;

   char_class_type    cls;
   logic              accept;
   logic              out_free;
   logic              last_byte;

   kt_char_class u_class (
      .text_byte (req_item.text_byte),
      .cls       (cls)
   );

   assign req_item.ready     = (state_ff == ST_IDLE);
   assign accept             = req_item.valid & req_item.ready;
   assign out_free           = ~rsp_valid_ff | rsp_item.ready;
   assign last_byte          = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);

   assign rsp_item.valid     = rsp_valid_ff;
   assign rsp_item.word_byte = word_byte_ff;
   assign rsp_item.word_end  = word_end_ff;

   // sequencer: buffer bytes, then read the word out one byte a cycle while the output is free
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      skip_in      = skip_ff;
      idx_in       = idx_ff;
      rd_addr      = idx_ff;
      wr_en        = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_item.ready;
      word_byte_in = word_byte_ff;
      word_end_in  = word_end_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (skip_ff) begin
                  // overlong word: drop bytes until a non-ascii-word byte
                  count_in = '0;
                  if (!cls.ascii_word) begin
                     skip_in = 1'b0;
                  end
               end else if (cls.word) begin
                  if (count_ff == CNT_W'(MAX_WORD_BYTES)) begin
                     count_in = '0;
                     skip_in  = 1'b1;
                  end else begin
                     wr_en    = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                  end
               end else if (count_ff >= CNT_W'(KT_MIN_KEEP_BYTES)) begin
                  // delimiter or end of text with a word worth keeping
                  idx_in   = '0;
                  state_in = ST_FETCH;
               end else begin
                  count_in = '0;
               end
            end
         end
         ST_FETCH: begin
            // first read of the word is in flight
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               word_byte_in = rd_data_ff;
               word_end_in  = last_byte;
               if (last_byte) begin
                  count_in = '0;
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + ADDR_W'(1);
                  rd_addr  = idx_ff + ADDR_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         skip_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         skip_ff      <= skip_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      word_byte_ff <= word_byte_in;
      word_end_ff  <= word_end_in;
   end

   // word store write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         word_store[count_ff[ADDR_W-1:0]] <= req_item.text_byte;
      end
   end

   // word store read port
   always_ff @(posedge clock) begin
      rd_data_ff <= word_store[rd_addr];
   end

endmodule

/* sv/kt_char_class.sv */
// byte classifier: ascii word bytes, latin-1 letters, end of text
module kt_char_class (
   input  logic [7:0]              text_byte,
   output kt_pkg::char_class_type  cls
);
   import kt_pkg::*;

   logic is_alnum;
   logic is_latin;

   // ascii letters, digits and hyphen
   assign is_alnum = ((text_byte >= KT_LOWER_LO) && (text_byte <= KT_LOWER_HI)) ||
                     ((text_byte >= KT_UPPER_LO) && (text_byte <= KT_UPPER_HI)) ||
                     ((text_byte >= KT_DIGIT_LO) && (text_byte <= KT_DIGIT_HI)) ||
                     (text_byte == KT_HYPHEN);

   // the seven latin-1 letters
   assign is_latin = (text_byte == KT_LAT_A_UML_LC) || (text_byte == KT_LAT_O_UML_LC) ||
                     (text_byte == KT_LAT_U_UML_LC) || (text_byte == KT_LAT_A_UML_UC) ||
                     (text_byte == KT_LAT_O_UML_UC) || (text_byte == KT_LAT_U_UML_UC) ||
                     (text_byte == KT_LAT_SHARP_S);

   always_comb begin
      cls.ascii_word  = is_alnum;
      cls.word        = is_alnum | is_latin;
      cls.end_of_text = (text_byte == KT_END_OF_TEXT);
   end

endmodule

/* verif/tb_keyword_tokenizer.sv */
// testbench of the keyword tokenizer: byte-stream stimulus, word predictor and keyword checker
module tb_keyword_tokenizer;
   import kt_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned WORD_MAX   = 48;
   localparam int unsigned IDLE_LIMIT = 1000;
   localparam int unsigned RAND_ITEMS = 16;

   // predictor of emitted keywords and store of expected keyword bytes
   class keyword_scoreboard;
      typedef struct packed {
         logic [7:0] word_byte;
         logic       word_end;
      } keyword_byte_type;

      logic [7:0]       word_buf [WORD_MAX];
      int unsigned      buf_count;
      bit               skipping;
      keyword_byte_type keyword_q [$];
      int unsigned      error_count;

      function new();
         buf_count   = 0;
         skipping    = 0;
         error_count = 0;
      endfunction

      function bit is_ascii_word(logic [7:0] c);
         return (c >= KT_LOWER_LO && c <= KT_LOWER_HI) ||
                (c >= KT_UPPER_LO && c <= KT_UPPER_HI) ||
                (c >= KT_DIGIT_LO && c <= KT_DIGIT_HI) || c == KT_HYPHEN;
      endfunction

      function bit is_word(logic [7:0] c);
         return is_ascii_word(c) ||
                c == KT_LAT_A_UML_LC || c == KT_LAT_O_UML_LC || c == KT_LAT_U_UML_LC ||
                c == KT_LAT_A_UML_UC || c == KT_LAT_O_UML_UC || c == KT_LAT_U_UML_UC ||
                c == KT_LAT_SHARP_S;
      endfunction

      function int unsigned pending();
         return keyword_q.size();
      endfunction

      // take one accepted text item and queue the keyword bytes it releases
      function void note_text(logic [7:0] c);
         keyword_byte_type kb;
         // overlong word: only ascii word bytes keep the skip going
         if (skipping) begin
            if (!is_ascii_word(c))
               skipping = 0;
            buf_count = 0;
            return;
         end
         if (is_word(c)) begin
            if (buf_count >= WORD_MAX) begin
               buf_count = 0;
               skipping  = 1;
            end else begin
               word_buf[buf_count] = c;
               buf_count++;
            end
            return;
         end
         // delimiter or end of text: release a word of keepable length
         if (buf_count >= KT_MIN_KEEP_BYTES) begin
            for (int unsigned i = 0; i < buf_count; i++) begin
               kb.word_byte = word_buf[i];
               kb.word_end  = (i + 1 == buf_count);
               keyword_q.push_back(kb);
            end
         end
         buf_count = 0;
      endfunction

      task report(string msg);
         $display("[%0t] mismatch: %s", $realtime, msg);
         error_count++;
      endtask

      // compare one accepted keyword byte with the oldest expected one
      task check_word_byte(logic [7:0] b, logic e);
         keyword_byte_type kb;
         if (keyword_q.size() == 0) begin
            report($sformatf("unexpected keyword byte %02h end %b", b, e));
            return;
         end
         kb = keyword_q.pop_front();
         if (b !== kb.word_byte)
            report($sformatf("word_byte %02h, expected %02h", b, kb.word_byte));
         if (e !== kb.word_end)
            report($sformatf("word_end %b on byte %02h, expected %b", e, b, kb.word_end));
      endtask
   endclass

   logic clock;
   logic reset;
   bit   idle_mode;
   int unsigned idle_cycles;

   kt_req_if req_if ();
   kt_rsp_if rsp_if ();

   keyword_scoreboard sb = new();

   keyword_tokenizer #(
      .MAX_WORD_BYTES(WORD_MAX)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_item (req_if),
      .rsp_item (rsp_if)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // random text bytes
   function automatic logic [7:0] pick_word_byte();
      case ($urandom_range(0, 9))
         0, 1, 2: return KT_LOWER_LO + 8'($urandom_range(0, 25));
         3, 4:    return KT_UPPER_LO + 8'($urandom_range(0, 25));
         5, 6:    return KT_DIGIT_LO + 8'($urandom_range(0, 9));
         7:       return KT_HYPHEN;
         default: begin
            case ($urandom_range(0, 6))
               0:       return KT_LAT_A_UML_LC;
               1:       return KT_LAT_O_UML_LC;
               2:       return KT_LAT_U_UML_LC;
               3:       return KT_LAT_A_UML_UC;
               4:       return KT_LAT_O_UML_UC;
               5:       return KT_LAT_U_UML_UC;
               default: return KT_LAT_SHARP_S;
            endcase
         end
      endcase
   endfunction

   function automatic logic [7:0] pick_delimiter();
      logic [7:0] c;
      do
         c = 8'($urandom_range(1, 255));
      while (sb.is_word(c));
      return c;
   endfunction

   // drive one text item, entered and left at a falling edge
   task send_text(input logic [7:0] c);
      int unsigned gap;
      gap = idle_mode ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         req_if.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid     = 1'b1;
      req_if.text_byte = c;
      do
         @(posedge clock);
      while (!req_if.ready);
      @(negedge clock);
   endtask

   task send_word(input int unsigned len);
      for (int unsigned i = 0; i < len; i++)
         send_text(pick_word_byte());
   endtask

   // hold the text side until every keyword byte has come out
   task drain_keywords();
      req_if.valid = 1'b0;
      while (sb.pending() != 0)
         @(negedge clock);
   endtask

   // keyword side: random stalls before each item in idle mode
   initial begin
      int unsigned stall;
      rsp_if.ready = 1'b0;
      @(negedge clock);
      while (reset)
         @(negedge clock);
      forever begin
         stall = idle_mode ? $urandom_range(0, 7) : 0;
         if (stall > 0) begin
            rsp_if.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_if.ready = 1'b1;
         do
            @(posedge clock);
         while (!rsp_if.valid);
         @(negedge clock);
      end
   end

   // monitor of both channels and watchdog
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready)
            sb.check_word_byte(rsp_if.word_byte, rsp_if.word_end);
         if (req_if.valid && req_if.ready)
            sb.note_text(req_if.text_byte);
         if ((rsp_if.valid && rsp_if.ready) || (req_if.valid && req_if.ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // stimulus
   initial begin
      int unsigned sent;
      int unsigned sel;
      reset            = 1'b1;
      idle_mode        = 1'b1;
      req_if.valid     = 1'b0;
      req_if.text_byte = 8'h00;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // shortest kept word with range edges, closed by the top byte value
      send_text(KT_UPPER_LO);
      send_text(KT_LOWER_HI);
      send_text(KT_DIGIT_LO);
      send_text(8'hFF);
      // two-byte and one-byte words are dropped
      send_text(KT_DIGIT_HI);
      send_text(KT_HYPHEN);
      send_text(8'h2F);
      send_text(KT_LOWER_LO);
      send_text(8'h7F);
      // all latin-1 letters form a word, closed by a high delimiter
      send_text(KT_LAT_A_UML_LC);
      send_text(KT_LAT_O_UML_LC);
      send_text(KT_LAT_U_UML_LC);
      send_text(KT_LAT_A_UML_UC);
      send_text(KT_LAT_O_UML_UC);
      send_text(KT_LAT_U_UML_UC);
      send_text(KT_LAT_SHARP_S);
      send_text(8'h80);
      // a one-byte word, then delimiters just outside the word ranges
      send_text(KT_UPPER_HI);
      send_text(8'h40);
      send_text(8'h5B);
      send_text(8'h60);
      // word closed by end of text, then an empty text
      send_text(KT_HYPHEN);
      send_text(KT_LOWER_LO);
      send_text(KT_UPPER_HI);
      send_text(KT_END_OF_TEXT);
      send_text(KT_END_OF_TEXT);

      // longest kept word
      send_word(WORD_MAX);
      send_text(8'h20);
      // overlong word, skip ended by a latin-1 letter, then a fresh word
      send_word(WORD_MAX + 1);
      send_text(KT_LOWER_LO);
      send_text(KT_DIGIT_HI);
      send_text(KT_LAT_SHARP_S);
      send_word(3);
      send_text(8'h2C);
      // overlong word ended by end of text
      send_word(WORD_MAX + 1);
      send_text(KT_END_OF_TEXT);
      send_word(4);
      send_text(8'h3A);
      drain_keywords();

      // random text: short words, some noise and end of text
      sent = 0;
      while (sent < RAND_ITEMS) begin
         if ($urandom_range(0, 9) == 0)
            idle_mode = ~idle_mode;
         if (sent >= RAND_ITEMS / 2 && sent < RAND_ITEMS / 2 + 8)
            drain_keywords();
         sel = $urandom_range(0, 9);
         if (sel <= 6) begin
            int unsigned len;
            len = $urandom_range(1, 8);
            send_word(len);
            send_text(($urandom_range(0, 7) == 0) ? KT_END_OF_TEXT : pick_delimiter());
            sent += len + 1;
         end else if (sel <= 8) begin
            send_text(8'($urandom_range(0, 255)));
            sent++;
         end else begin
            send_text(KT_END_OF_TEXT);
            sent++;
         end
      end
      send_text(KT_END_OF_TEXT);
      req_if.valid = 1'b0;

      // let the last keyword come out, then a short tail
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.pending() != 0)
         sb.report($sformatf("%0d keyword bytes never came out", sb.pending()));
      if (sb.error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

/* keyword_tokenizer.f */
sv/kt_pkg.sv
sv/kt_if.sv
sv/kt_char_class.sv
sv/keyword_tokenizer.sv
verif/tb_keyword_tokenizer.sv
